>>> src/particle_density_binning_3d_assert.svh
// Assertion macros shared by the binning block.
// PDB_ASSERT checks a property on the rising clock edge, off during reset.
// PDB_IMPLY checks that one condition implies another in the same cycle.
`ifndef PARTICLE_DENSITY_BINNING_3D_ASSERT_SVH
`define PARTICLE_DENSITY_BINNING_3D_ASSERT_SVH
`ifndef SYNTHESIS
`define PDB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
`define PDB_IMPLY(label, clk, rst_n, ante, cons) \
    `PDB_ASSERT(label, clk, rst_n, (ante) |-> (cons))
`else
`define PDB_ASSERT(label, clk, rst_n, prop)
`define PDB_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pdb_pkg.sv
package pdb_pkg;

    // Parameter defaults
    localparam int MAX_AXIS_CELLS_DEF = 32;
    localparam int COUNT_BITS_DEF     = 16;
    localparam int POS_FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH        = 2;

    // Fixed field widths
    localparam int POS_BITS       = 24;
    localparam int INDEX_BITS     = 15;
    localparam int OUT_COUNT_BITS = 16;
    localparam int DENS_BITS      = 48;
    localparam int INV_SIZE_BITS  = 24;
    localparam int CELLS_BITS     = 6;
    localparam int INV_VOL_BITS   = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_CELL_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CELLS_PER_AXIS  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_CELL_VOLUME = 2'd2;

    // Register reset values
    localparam logic [INV_SIZE_BITS-1:0] INV_CELL_SIZE_RST   = 24'd44059;
    localparam logic [CELLS_BITS-1:0]    CELLS_PER_AXIS_RST  = 6'd16;
    localparam logic [INV_VOL_BITS-1:0]  INV_CELL_VOLUME_RST = 32'd19912;

    // Operation codes
    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_y;
        logic [POS_BITS-1:0]   pos_z;
        logic [INDEX_BITS-1:0] read_cell;
    } item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]     cell_index;
        logic [OUT_COUNT_BITS-1:0] cell_count;
        logic [DENS_BITS-1:0]      cell_density;
        logic                      out_of_grid;
    } result_t;

    typedef struct packed {
        logic [INV_SIZE_BITS-1:0] inv_cell_size;
        logic [CELLS_BITS-1:0]    cells_per_axis;
        logic [INV_VOL_BITS-1:0]  inv_cell_volume;
    } cfg_t;

    // Control part of a queued word; the store address follows it
    typedef struct packed {
        logic                  op;
        logic                  drop;
        logic                  inval;
        logic [INDEX_BITS-1:0] index;
    } qctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WRAP,
        F_IDX1,
        F_IDX2
    } fstate_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_UPDATE,
        B_DENS,
        B_OUT
    } bstate_t;

endpackage

>>> src/pdb_queue.sv
`include "particle_density_binning_3d_assert.svh"

module pdb_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = pdb_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [DW-1:0]      push_data,
    input  logic               pop,
    output logic [DW-1:0]      pop_data,
    output pdb_pkg::qstat_t    stat
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   slots [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = slots[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNTW'(DEPTH));

    `PDB_IMPLY(a_no_push_full, clk, rst_n, push, !stat.full)
    `PDB_IMPLY(a_no_pop_empty, clk, rst_n, pop, !stat.empty)

endmodule

>>> src/pdb_front.sv
module pdb_front #(
    parameter int  MAX_AXIS_CELLS = pdb_pkg::MAX_AXIS_CELLS_DEF,
    parameter int  POS_FRAC_BITS  = pdb_pkg::POS_FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_AXIS_CELLS * MAX_AXIS_CELLS * MAX_AXIS_CELLS),
    localparam int QW = $bits(pdb_pkg::qctl_t) + AW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  pdb_pkg::item_t  item,
    input  pdb_pkg::cfg_t   cfg,
    output logic            front_busy,
    output logic            push,
    output logic [QW-1:0]   push_data
);

    localparam int DEPTH = MAX_AXIS_CELLS * MAX_AXIS_CELLS * MAX_AXIS_CELLS;
    localparam int NW    = $clog2(MAX_AXIS_CELLS + 1);
    localparam int CBW   = $clog2(MAX_AXIS_CELLS);
    localparam int TW    = $clog2(MAX_AXIS_CELLS * MAX_AXIS_CELLS);
    localparam int PW    = 2 * pdb_pkg::POS_BITS;
    localparam int SH    = 2 * POS_FRAC_BITS;
    localparam int CW    = (PW - SH > 0) ? PW - SH : 1;
    localparam int EW    = (CW > NW) ? CW : NW;
    localparam int M1W   = NW + CBW;
    localparam int M2W   = NW + TW;

    pdb_pkg::fstate_t state_reg, state_next;

    logic                           op_reg, op_next;
    logic [pdb_pkg::INDEX_BITS-1:0] rc_reg, rc_next;
    logic [PW-1:0]                  prod_x_reg, prod_x_next;
    logic [PW-1:0]                  prod_y_reg, prod_y_next;
    logic [PW-1:0]                  prod_z_reg, prod_z_next;
    logic [CBW-1:0]                 cx_reg, cx_next;
    logic [CBW-1:0]                 cy_reg, cy_next;
    logic [CBW-1:0]                 cz_reg, cz_next;
    logic                           ok_reg, ok_next;
    logic [TW-1:0]                  t_reg, t_next;

    logic [NW-1:0]  n;
    logic [CBW:0]   wx, wy, wz;
    logic [M1W-1:0] m1;
    logic [M2W-1:0] m2;
    logic [AW-1:0]  idx;
    pdb_pkg::qctl_t ctl;
    logic [AW-1:0]  addr;

    // Floor of the scaled position, wrapped once; msb flags a valid cell
    function automatic logic [CBW:0] wrap_coord(input logic [PW-1:0] prod,
                                                input logic [NW-1:0] cells);
        logic [EW-1:0] c;
        logic [EW-1:0] nn;
        logic [EW-1:0] c1;
        c  = EW'(prod >> SH);
        nn = EW'(cells);
        c1 = (c >= nn) ? c - nn : c;
        return {(c1 < nn), CBW'(c1)};
    endfunction

    // Clamp the grid size to 1..MAX_AXIS_CELLS
    always_comb
    begin
        if (cfg.cells_per_axis == '0)
        begin
            n = NW'(1);
        end
        else if (int'(cfg.cells_per_axis) > MAX_AXIS_CELLS)
        begin
            n = NW'(MAX_AXIS_CELLS);
        end
        else
        begin
            n = NW'(cfg.cells_per_axis);
        end
    end

    assign wx  = wrap_coord(prod_x_reg, n);
    assign wy  = wrap_coord(prod_y_reg, n);
    assign wz  = wrap_coord(prod_z_reg, n);
    // Horner form of x + n*(y + n*z), one product per stage
    assign m1  = M1W'(n) * M1W'(cz_reg);
    assign m2  = M2W'(n) * M2W'(t_reg);
    assign idx = AW'(m2) + AW'(cx_reg);

    // Queue word for the back part
    always_comb
    begin
        if (op_reg == pdb_pkg::OP_READ)
        begin
            ctl.op    = pdb_pkg::OP_READ;
            ctl.drop  = 1'b0;
            ctl.inval = (int'(rc_reg) >= DEPTH);
            ctl.index = rc_reg;
            addr      = AW'(rc_reg);
        end
        else
        begin
            ctl.op    = pdb_pkg::OP_DEPOSIT;
            ctl.drop  = !ok_reg;
            ctl.inval = 1'b0;
            ctl.index = ok_reg ? pdb_pkg::INDEX_BITS'(idx) : '0;
            addr      = idx;
        end
    end

    assign push_data  = {ctl, addr};
    assign front_busy = (state_reg != pdb_pkg::F_IDLE);

    // Sequencer: products, wrap, two index steps, push
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        rc_next     = rc_reg;
        prod_x_next = prod_x_reg;
        prod_y_next = prod_y_reg;
        prod_z_next = prod_z_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        ok_next     = ok_reg;
        t_next      = t_reg;
        push        = 1'b0;
        unique case (state_reg)
            pdb_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    op_next     = item.op;
                    rc_next     = item.read_cell;
                    prod_x_next = PW'(item.pos_x) * PW'(cfg.inv_cell_size);
                    prod_y_next = PW'(item.pos_y) * PW'(cfg.inv_cell_size);
                    prod_z_next = PW'(item.pos_z) * PW'(cfg.inv_cell_size);
                    state_next  = pdb_pkg::F_WRAP;
                end
            end
            pdb_pkg::F_WRAP:
            begin
                cx_next    = wx[CBW-1:0];
                cy_next    = wy[CBW-1:0];
                cz_next    = wz[CBW-1:0];
                ok_next    = wx[CBW] && wy[CBW] && wz[CBW];
                state_next = pdb_pkg::F_IDX1;
            end
            pdb_pkg::F_IDX1:
            begin
                t_next     = TW'(m1) + TW'(cy_reg);
                state_next = pdb_pkg::F_IDX2;
            end
            pdb_pkg::F_IDX2:
            begin
                push       = 1'b1;
                state_next = pdb_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdb_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        rc_reg     <= rc_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        ok_reg     <= ok_next;
        t_reg      <= t_next;
    end

endmodule

>>> src/pdb_back.sv
`include "particle_density_binning_3d_assert.svh"

module pdb_back #(
    parameter int  MAX_AXIS_CELLS = pdb_pkg::MAX_AXIS_CELLS_DEF,
    parameter int  COUNT_BITS     = pdb_pkg::COUNT_BITS_DEF,
    localparam int AW = $clog2(MAX_AXIS_CELLS * MAX_AXIS_CELLS * MAX_AXIS_CELLS),
    localparam int QW = $bits(pdb_pkg::qctl_t) + AW
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pdb_pkg::cfg_t     cfg,
    input  pdb_pkg::qstat_t   stat,
    output logic              pop,
    input  logic [QW-1:0]     pop_data,
    output logic              clearing,
    output logic              result_valid,
    output pdb_pkg::result_t  result
);

    localparam int DEPTH = MAX_AXIS_CELLS * MAX_AXIS_CELLS * MAX_AXIS_CELLS;
    localparam int PW    = COUNT_BITS + pdb_pkg::INV_VOL_BITS;

    pdb_pkg::bstate_t state_reg, state_next;

    logic [AW-1:0]         clr_reg, clr_next;
    pdb_pkg::qctl_t        ctl_reg, ctl_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]         prod_reg, prod_next;
    pdb_pkg::result_t      result_reg, result_next;
    logic                  valid_reg, valid_next;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic                  access;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  dens_sat;

    assign access   = !ctl_reg.drop && !ctl_reg.inval;
    // Saturating increment of the stored count
    assign cnt_inc  = (rd_data_reg == {COUNT_BITS{1'b1}}) ?
                      rd_data_reg : rd_data_reg + COUNT_BITS'(1);
    assign dens_sat = |(prod_reg >> pdb_pkg::DENS_BITS);

    // Clear sweep, then read-modify-write of one cell per word
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ctl_next    = ctl_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        result_next = result_reg;
        valid_next  = 1'b0;
        pop         = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = '0;
        unique case (state_reg)
            pdb_pkg::B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = pdb_pkg::B_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            pdb_pkg::B_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop                   = 1'b1;
                    {ctl_next, addr_next} = pop_data;
                    state_next            = pdb_pkg::B_READ;
                end
            end
            pdb_pkg::B_READ:
            begin
                mem_re     = 1'b1;
                state_next = pdb_pkg::B_UPDATE;
            end
            pdb_pkg::B_UPDATE:
            begin
                if (access)
                begin
                    mem_we = 1'b1;
                    if (ctl_reg.op == pdb_pkg::OP_READ)
                    begin
                        cnt_next  = rd_data_reg;
                        mem_wdata = '0;
                    end
                    else
                    begin
                        cnt_next  = cnt_inc;
                        mem_wdata = cnt_inc;
                    end
                end
                else
                begin
                    cnt_next = '0;
                end
                state_next = pdb_pkg::B_DENS;
            end
            pdb_pkg::B_DENS:
            begin
                prod_next  = PW'(cnt_reg) * PW'(cfg.inv_cell_volume);
                state_next = pdb_pkg::B_OUT;
            end
            pdb_pkg::B_OUT:
            begin
                result_next.cell_index   = ctl_reg.index;
                result_next.cell_count   = pdb_pkg::OUT_COUNT_BITS'(cnt_reg);
                result_next.cell_density = dens_sat ? {pdb_pkg::DENS_BITS{1'b1}} :
                                           pdb_pkg::DENS_BITS'(prod_reg);
                result_next.out_of_grid  = ctl_reg.drop;
                valid_next               = 1'b1;
                state_next               = pdb_pkg::B_IDLE;
            end
            default:
            begin
                state_next = pdb_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdb_pkg::B_CLEAR;
            clr_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg    <= ctl_next;
        addr_reg   <= addr_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    // Count store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign clearing     = (state_reg == pdb_pkg::B_CLEAR);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    `PDB_ASSERT(a_strobe_single, clk, rst_n, valid_reg |=> !valid_reg)
    `PDB_ASSERT(a_out_strobes, clk, rst_n, (state_reg == pdb_pkg::B_OUT) |=> valid_reg)
    `PDB_IMPLY(a_drop_empty, clk, rst_n, valid_reg && result_reg.out_of_grid,
               result_reg.cell_count == '0 && result_reg.cell_density == '0)

endmodule

>>> src/particle_density_binning_3d.sv
// Nearest-grid-point particle histogram over a cubic grid of cells.
// Command channel: a word (item) is taken at a rising edge with start high
// and busy low. op 0 deposits a particle at pos_x/y/z; op 1 reads and
// clears the cell read_cell.
// Result channel: each word gives exactly one result, shown for one cycle
// with result_valid high; the receiver cannot stall it, so nothing backs up.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while no command is in flight. cfg_ready is always high.
// Flow: the front part (coordinate products, wrap, two index steps) handles
// one word at a time and pushes it into a 2-word queue; the back part pops
// each word and does the read-modify-write of the count store (read, update,
// density, output). The queue lets the front take new words while the back is
// still busy; busy reflects a full queue as well as a busy front part.
// Reset: registers take their reset values and the count store is cleared
// by a sweep over all MAX_AXIS_CELLS^3 entries (32768 by default), one entry
// a cycle; busy stays high for that sweep.
module particle_density_binning_3d #(
    parameter int MAX_AXIS_CELLS = pdb_pkg::MAX_AXIS_CELLS_DEF,
    parameter int COUNT_BITS     = pdb_pkg::COUNT_BITS_DEF,
    parameter int POS_FRAC_BITS  = pdb_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pdb_pkg::item_t                     item,
    output logic                               result_valid,
    output pdb_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pdb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_AXIS_CELLS * MAX_AXIS_CELLS * MAX_AXIS_CELLS);
    localparam int QW = $bits(pdb_pkg::qctl_t) + AW;

    pdb_pkg::cfg_t   cfg_reg, cfg_next;
    pdb_pkg::qstat_t qstat;
    logic            accept;
    logic            front_busy;
    logic            clearing;
    logic            push;
    logic            pop;
    logic [QW-1:0]   push_data;
    logic [QW-1:0]   pop_data;

    // Configuration register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pdb_pkg::CFG_INV_CELL_SIZE:
                    cfg_next.inv_cell_size = pdb_pkg::INV_SIZE_BITS'(cfg_data);
                pdb_pkg::CFG_CELLS_PER_AXIS:
                    cfg_next.cells_per_axis = pdb_pkg::CELLS_BITS'(cfg_data);
                pdb_pkg::CFG_INV_CELL_VOLUME:
                    cfg_next.inv_cell_volume = pdb_pkg::INV_VOL_BITS'(cfg_data);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_cell_size   <= pdb_pkg::INV_CELL_SIZE_RST;
            cfg_reg.cells_per_axis  <= pdb_pkg::CELLS_PER_AXIS_RST;
            cfg_reg.inv_cell_volume <= pdb_pkg::INV_CELL_VOLUME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Command handshake
    assign busy   = clearing || front_busy || qstat.full;
    assign accept = start && !busy;

    pdb_front #(
        .MAX_AXIS_CELLS (MAX_AXIS_CELLS),
        .POS_FRAC_BITS  (POS_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .cfg        (cfg_reg),
        .front_busy (front_busy),
        .push       (push),
        .push_data  (push_data)
    );

    pdb_queue #(
        .DW    (QW),
        .DEPTH (pdb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (qstat)
    );

    pdb_back #(
        .MAX_AXIS_CELLS (MAX_AXIS_CELLS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .stat         (qstat),
        .pop          (pop),
        .pop_data     (pop_data),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> sim/tb_particle_density_binning_3d.sv
`timescale 1ns / 100ps

module tb_particle_density_binning_3d;
    import pdb_pkg::*;

    localparam int STORE_CELLS = 32768;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [15:0] COUNT_FULL = 16'hFFFF;
    localparam logic [47:0] DENSITY_FULL = 48'hFFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item = '0;
    logic result_valid;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Shadow of the histogram and its registers
    logic [15:0] count_mem [0:STORE_CELLS-1];
    logic [INV_SIZE_BITS-1:0] inv_size_m;
    logic [CELLS_BITS-1:0] cells_m;
    logic [INV_VOL_BITS-1:0] inv_vol_m;

    result_t pending_results [$];
    logic [INDEX_BITS-1:0] hot_cells [$];

    int send_idle_pct = 0;
    int err_count = 0;
    int n_deposit = 0;
    int n_dropped = 0;
    int n_read = 0;
    int n_cfg = 0;
    int n_results = 0;
    int n_full = 0;

    particle_density_binning_3d dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic int grid_cells();
        int n;
        n = int'(cells_m);
        if (n == 0) n = 1;
        if (n > MAX_AXIS_CELLS_DEF) n = MAX_AXIS_CELLS_DEF;
        return n;
    endfunction

    // floor(pos * inv_size), wrapped once; 0 when still off the grid
    function automatic bit axis_cell(input logic [POS_BITS-1:0] pos, input int n,
                                     output longint unsigned c);
        logic [47:0] prod;
        prod = 48'(pos) * 48'(inv_size_m);
        c = 64'(prod >> 32);
        if (c >= n) c = c - n;
        return (c < n);
    endfunction

    function automatic logic [47:0] density_of(input logic [15:0] cnt);
        logic [63:0] p;
        p = 64'(cnt) * 64'(inv_vol_m);
        if (p > 64'(DENSITY_FULL)) return DENSITY_FULL;
        return p[47:0];
    endfunction

    // Expected result of one accepted word; updates the shadow store
    function automatic result_t bin_word(input item_t w);
        result_t r;
        int n;
        longint unsigned cx, cy, cz;
        bit ok;
        int idx;
        r = '0;
        if (w.op == OP_DEPOSIT) begin
            n = grid_cells();
            ok = axis_cell(w.pos_x, n, cx);
            ok &= axis_cell(w.pos_y, n, cy);
            ok &= axis_cell(w.pos_z, n, cz);
            n_deposit++;
            if (!ok) begin
                r.out_of_grid = 1'b1;
                n_dropped++;
            end else begin
                idx = int'(cx + cy * n + cz * n * n);
                if (count_mem[idx] != COUNT_FULL) count_mem[idx] = count_mem[idx] + 16'd1;
                r.cell_index = idx[INDEX_BITS-1:0];
                r.cell_count = count_mem[idx];
                r.cell_density = density_of(count_mem[idx]);
                hot_cells.push_back(idx[INDEX_BITS-1:0]);
                if (hot_cells.size() > 64) void'(hot_cells.pop_front());
            end
        end else begin
            idx = int'(w.read_cell);
            r.cell_index = w.read_cell;
            r.cell_count = count_mem[idx];
            r.cell_density = density_of(count_mem[idx]);
            count_mem[idx] = '0;
            n_read++;
        end
        if (r.cell_count == COUNT_FULL) n_full++;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    // Smallest position that lands in cell coordinate c at the current scale
    function automatic logic [POS_BITS-1:0] pos_of_cell(input int c);
        longint unsigned p;
        if (inv_size_m == 0) return '0;
        p = ((64'(c) << 32) + 64'(inv_size_m) - 1) / 64'(inv_size_m);
        if (p > 64'hFF_FFFF) p = 64'hFF_FFFF;
        return p[POS_BITS-1:0];
    endfunction

    function automatic item_t mk_deposit(input logic [POS_BITS-1:0] x, y, z);
        item_t w;
        w.op = OP_DEPOSIT;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        w.read_cell = INDEX_BITS'($urandom());
        return w;
    endfunction

    function automatic item_t mk_read(input logic [INDEX_BITS-1:0] idx);
        item_t w;
        w.op = OP_READ;
        w.pos_x = POS_BITS'($urandom());
        w.pos_y = POS_BITS'($urandom());
        w.pos_z = POS_BITS'($urandom());
        w.read_cell = idx;
        return w;
    endfunction

    // Mostly inside the grid, some in the wrap band, some beyond it
    function automatic logic [POS_BITS-1:0] pick_pos();
        int r;
        int k;
        longint unsigned span;
        r = $urandom_range(0, 99);
        if (r < 8 || inv_size_m == 0) return POS_BITS'($urandom());
        k = (r < 65) ? 1 : (r < 88) ? 2 : 3;
        span = (64'(k * grid_cells()) << 32) / 64'(inv_size_m);
        if (span > 64'hFF_FFFF) span = 64'hFF_FFFF;
        return POS_BITS'($urandom_range(0, int'(span)));
    endfunction

    function automatic item_t random_word();
        if ($urandom_range(0, 3) == 0) begin
            if (hot_cells.size() != 0 && $urandom_range(0, 9) < 6)
                return mk_read(hot_cells[$urandom_range(0, hot_cells.size() - 1)]);
            return mk_read(INDEX_BITS'($urandom()));
        end
        return mk_deposit(pick_pos(), pick_pos(), pick_pos());
    endfunction

    // ---------------- driving ----------------

    // Send one word; start stays high afterwards so back-to-back words need no gap
    task automatic send_word(input item_t w);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results.push_back(bin_word(w));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_INV_CELL_SIZE:   inv_size_m = data[INV_SIZE_BITS-1:0];
            CFG_CELLS_PER_AXIS:  cells_m = data[CELLS_BITS-1:0];
            CFG_INV_CELL_VOLUME: inv_vol_m = data[INV_VOL_BITS-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Register writes carry junk above the field to check the masking
    task automatic set_grid(input logic [CELLS_BITS-1:0] cells);
        logic [CFG_DATA_BITS-1:0] d;
        d = $urandom();
        d[CELLS_BITS-1:0] = cells;
        cfg_write(CFG_CELLS_PER_AXIS, d);
    endtask

    task automatic set_scale(input logic [INV_SIZE_BITS-1:0] inv_size,
                             input logic [INV_VOL_BITS-1:0] inv_vol);
        logic [CFG_DATA_BITS-1:0] d;
        d = $urandom();
        d[INV_SIZE_BITS-1:0] = inv_size;
        cfg_write(CFG_INV_CELL_SIZE, d);
        cfg_write(CFG_INV_CELL_VOLUME, inv_vol);
    endtask

    // ---------------- result checker ----------------

    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n && result_valid) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: index %0d count %0d",
                       result.cell_index, result.cell_count);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (result.cell_index !== exp_r.cell_index) begin
                    $error("cell_index: expected %0d, got %0d",
                           exp_r.cell_index, result.cell_index);
                    err_count++;
                end
                if (result.cell_count !== exp_r.cell_count) begin
                    $error("cell_count: expected %0d, got %0d",
                           exp_r.cell_count, result.cell_count);
                    err_count++;
                end
                if (result.cell_density !== exp_r.cell_density) begin
                    $error("cell_density: expected %0h, got %0h",
                           exp_r.cell_density, result.cell_density);
                    err_count++;
                end
                if (result.out_of_grid !== exp_r.out_of_grid) begin
                    $error("out_of_grid: expected %0b, got %0b",
                           exp_r.out_of_grid, result.out_of_grid);
                    err_count++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // Reset register values: 16 cells per axis, wrap band and drops
    task automatic test_reset_defaults();
        send_word(mk_read('0));
        send_word(mk_read('1));
        send_word(mk_deposit('0, '0, '0));
        send_word(mk_deposit('0, '0, '0));
        send_word(mk_deposit('1, '1, '1));
        send_word(mk_deposit(pos_of_cell(15), pos_of_cell(15), pos_of_cell(15)));
        send_word(mk_deposit(pos_of_cell(20), pos_of_cell(1), pos_of_cell(31)));
        send_word(mk_deposit('0, '0, pos_of_cell(32)));
        send_word(mk_deposit('0, '0, '1));
        send_word(mk_read('0));
        send_word(mk_read('0));
        send_word(mk_read(15'd4095));
        drain();
    endtask

    // Grid size at and beyond both ends, reads outside the current grid
    task automatic test_grid_sizes();
        set_grid(6'd32);
        send_word(mk_deposit(pos_of_cell(31), pos_of_cell(31), pos_of_cell(31)));
        send_word(mk_deposit(pos_of_cell(63), pos_of_cell(63), pos_of_cell(63)));
        drain();
        set_grid(6'd63);
        send_word(mk_deposit(pos_of_cell(31), pos_of_cell(31), pos_of_cell(31)));
        drain();
        set_grid(6'd2);
        send_word(mk_read('1));
        send_word(mk_deposit(pos_of_cell(1), pos_of_cell(1), pos_of_cell(1)));
        drain();
        set_grid(6'd0);
        send_word(mk_deposit(pos_of_cell(1), '0, '0));
        send_word(mk_deposit(pos_of_cell(2), '0, '0));
        drain();
        set_grid(6'd1);
        send_word(mk_deposit('0, '0, '0));
        send_word(mk_read('0));
        drain();
    endtask

    // Zero and full-scale inverse edge length and volume
    task automatic test_scale_extremes();
        set_grid(6'd32);
        set_scale('0, '0);
        send_word(mk_deposit('1, '1, '1));
        send_word(mk_read('0));
        drain();
        set_scale('1, '1);
        send_word(mk_deposit(24'd1, 24'd1, 24'd1));
        send_word(mk_deposit(24'h01_0000, '0, '0));
        send_word(mk_deposit(pos_of_cell(31), pos_of_cell(31), pos_of_cell(31)));
        send_word(mk_read('0));
        send_word(mk_read('1));
        drain();
    endtask

    // Repeated hits on one cell read back at the largest volume factor
    task automatic test_large_volume();
        set_scale(INV_CELL_SIZE_RST, '1);
        send_word(mk_read('0));
        for (int i = 0; i < 8; i++) send_word(mk_deposit('0, '0, '0));
        send_word(mk_read('0));
        drain();
    endtask

    task automatic random_config();
        logic [CELLS_BITS-1:0] cells;
        logic [INV_SIZE_BITS-1:0] inv_size;
        logic [INV_VOL_BITS-1:0] inv_vol;
        case ($urandom_range(0, 7))
            0: cells = 6'd1;
            1: cells = 6'd2;
            2: cells = 6'd32;
            3: cells = 6'd0;
            4: cells = CELLS_BITS'($urandom_range(33, 63));
            default: cells = CELLS_BITS'($urandom_range(1, 32));
        endcase
        case ($urandom_range(0, 5))
            0: inv_size = '0;
            1: inv_size = '1;
            2: inv_size = INV_SIZE_BITS'($urandom_range(1, 24'hFF_FFFF));
            default: inv_size = INV_SIZE_BITS'($urandom_range(24'h00_2000, 24'h04_0000));
        endcase
        case ($urandom_range(0, 4))
            0: inv_vol = '0;
            1: inv_vol = '1;
            2: inv_vol = $urandom();
            default: inv_vol = $urandom_range(1, 32'h0010_0000);
        endcase
        set_grid(cells);
        set_scale(inv_size, inv_vol);
    endtask

    // Random words under one sender idle rate, new settings every 96 words
    task automatic test_random_traffic(input int idle_pct, input int words);
        send_idle_pct = idle_pct;
        for (int i = 0; i < words; i++) begin
            if (i % 96 == 0) begin
                drain();
                random_config();
            end
            send_word(random_word());
        end
        drain();
    endtask

    // ---------------- sequence ----------------

    initial begin
        for (int i = 0; i < STORE_CELLS; i++) count_mem[i] = '0;
        inv_size_m = INV_CELL_SIZE_RST;
        cells_m = CELLS_PER_AXIS_RST;
        inv_vol_m = INV_CELL_VOLUME_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_grid_sizes();
        test_scale_extremes();
        test_large_volume();
        test_random_traffic(24, 385);
        test_random_traffic(53, 385);
        test_random_traffic(0, 385);

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            err_count++;
        end
        $display("covered %0d deposits (%0d off grid), %0d reads, %0d register writes",
                 n_deposit, n_dropped, n_read, n_cfg);
        $display("%0d results checked, %0d at the count maximum, %0d mismatches",
                 n_results, n_full, err_count);
        if (err_count == 0)
            $display("tb_particle_density_binning_3d: done, clean");
        else
            $display("tb_particle_density_binning_3d: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("tb_particle_density_binning_3d: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/pdb_pkg.sv
src/pdb_queue.sv
src/pdb_front.sv
src/pdb_back.sv
src/particle_density_binning_3d.sv
sim/tb_particle_density_binning_3d.sv
